// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescaper
// Byte constants and the result group that passes from the decoder to the
// output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // A string step causes at most six output bytes.
  localparam int GROUP_BYTES = 6;
  localparam int COUNT_W     = $clog2(GROUP_BYTES + 1);

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  // Bytes in output order: bytes[0] goes out first.
  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]          count;
    logic                        last;
  } group_t;

endpackage

`default_nettype wire

// ===== hdl/jsu_in_if.sv =====
// ----------------------------------------------------------------------------
// jsu_in_if: input channel of the unescaper
// Carries one string content byte per word and the end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/jsu_out_if.sv =====
// ----------------------------------------------------------------------------
// jsu_out_if: output channel of the unescaper
// Carries one decoded UTF-8 byte per word and the end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder and surrogate pairing
// Holds the escape state and turns one registered input byte into a group
// of up to six UTF-8 bytes; the state advances on fire, when the group can be stored.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  output jsu_pkg::group_t     grp
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_PLAIN, M_ESC, M_HEX, M_HELD, M_HELD_ESC, M_HELD_HEX
  } mode_t;

  typedef enum logic [1:0] {EM_NONE, EM_RAW, EM_CP} emit_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  localparam logic [20:0] CP_REPL = 21'h00FFFD;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < 21'h800) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

  mode_t       mode, mode_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic [9:0]  held_high, held_high_next;

  logic        rel;
  emit_t       kind;
  logic [7:0]  raw;
  logic [20:0] cp;

  // Plain-mode and escape-mode handling of the current byte.
  emit_t       p_kind, e_kind;
  logic [7:0]  p_raw, e_raw;
  mode_t       p_mode;
  logic        e_hex;

  logic        hx;
  logic [3:0]  hd;
  logic [15:0] acc_sh;
  logic [2:0]  cnt_inc;
  logic        acc_high, acc_low;

  enc_t        rel_enc, sec_enc;

  always_comb begin
    hx = 1'b1;
    hd = 4'd0;
    if (data_byte inside {[8'h30:8'h39]}) begin
      hd = data_byte[3:0];
    end else if (data_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hd = data_byte[3:0] + 4'd9;
    end else begin
      hx = 1'b0;
    end
  end

  assign acc_sh   = {code_accum[11:0], hd};
  assign cnt_inc  = digit_count + 3'd1;
  assign acc_high = (acc_sh >= 16'hD800) && (acc_sh <= 16'hDBFF);
  assign acc_low  = (acc_sh >= 16'hDC00) && (acc_sh <= 16'hDFFF);

  always_comb begin
    if (data_byte == CH_BACKSLASH) begin
      p_kind = last_byte ? EM_RAW : EM_NONE;
      p_raw  = CH_QUOTE;
      p_mode = last_byte ? M_PLAIN : M_ESC;
    end else begin
      p_kind = EM_RAW;
      p_raw  = data_byte;
      p_mode = M_PLAIN;
    end
  end

  always_comb begin
    e_kind = EM_RAW;
    e_raw  = data_byte;
    e_hex  = 1'b0;
    case (data_byte)
      8'h62: e_raw = 8'h08;
      8'h66: e_raw = 8'h0C;
      8'h6E: e_raw = 8'h0A;
      8'h72: e_raw = 8'h0D;
      8'h74: e_raw = 8'h09;
      8'h75: begin
        e_kind = last_byte ? EM_CP : EM_NONE;
        e_hex  = !last_byte;
      end
      default: e_raw = data_byte;
    endcase
  end

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    code_accum_next  = code_accum;
    held_high_next   = held_high;
    rel              = 1'b0;
    kind             = EM_NONE;
    raw              = data_byte;
    cp               = CP_REPL;

    case (mode)
      M_ESC: begin
        kind      = e_kind;
        raw       = e_raw;
        mode_next = e_hex ? M_HEX : M_PLAIN;
        if (e_hex) begin
          digit_count_next = '0;
          code_accum_next  = '0;
        end
      end
      M_HEX: begin
        mode_next = M_PLAIN;
        if (!hx) begin
          kind = EM_CP;
        end else begin
          code_accum_next  = acc_sh;
          digit_count_next = cnt_inc;
          if (cnt_inc >= 3'd4) begin
            if (acc_high && !last_byte) begin
              held_high_next = acc_sh[9:0];
              mode_next      = M_HELD;
            end else begin
              kind = EM_CP;
              cp   = {5'd0, acc_sh};
            end
          end else if (last_byte) begin
            kind = EM_CP;
          end else begin
            mode_next = M_HEX;
          end
        end
      end
      M_HELD: begin
        if (data_byte == CH_BACKSLASH && !last_byte) begin
          mode_next = M_HELD_ESC;
        end else begin
          rel            = 1'b1;
          held_high_next = '0;
          kind           = p_kind;
          raw            = p_raw;
          mode_next      = p_mode;
        end
      end
      M_HELD_ESC: begin
        if (data_byte == 8'h75 && !last_byte) begin
          mode_next        = M_HELD_HEX;
          digit_count_next = '0;
          code_accum_next  = '0;
        end else begin
          rel            = 1'b1;
          held_high_next = '0;
          kind           = e_kind;
          raw            = e_raw;
          mode_next      = e_hex ? M_HEX : M_PLAIN;
          if (e_hex) begin
            digit_count_next = '0;
            code_accum_next  = '0;
          end
        end
      end
      M_HELD_HEX: begin
        mode_next = M_PLAIN;
        if (!hx) begin
          rel            = 1'b1;
          held_high_next = '0;
          kind           = EM_CP;
        end else begin
          code_accum_next  = acc_sh;
          digit_count_next = cnt_inc;
          if (cnt_inc >= 3'd4) begin
            if (acc_low) begin
              // Surrogate pair: one supplementary code point.
              kind           = EM_CP;
              cp             = 21'h10000 + {1'b0, held_high, acc_sh[9:0]};
              held_high_next = '0;
            end else begin
              rel            = 1'b1;
              held_high_next = '0;
              if (acc_high && !last_byte) begin
                held_high_next = acc_sh[9:0];
                mode_next      = M_HELD;
              end else begin
                kind = EM_CP;
                cp   = {5'd0, acc_sh};
              end
            end
          end else if (last_byte) begin
            rel            = 1'b1;
            held_high_next = '0;
            kind           = EM_CP;
          end else begin
            mode_next = M_HELD_HEX;
          end
        end
      end
      default: begin
        kind      = p_kind;
        raw       = p_raw;
        mode_next = p_mode;
      end
    endcase

    // The end of a string returns every register to its reset value.
    if (last_byte) begin
      mode_next        = M_PLAIN;
      digit_count_next = '0;
      code_accum_next  = '0;
      held_high_next   = '0;
    end
  end

  always_comb begin
    rel_enc = utf8_enc({5'd0, 6'b110110, held_high});
    sec_enc = '0;
    case (kind)
      EM_RAW: begin
        sec_enc.b[0] = raw;
        sec_enc.len  = 3'd1;
      end
      EM_CP:   sec_enc = utf8_enc(cp);
      default: sec_enc = '0;
    endcase

    grp.last = last_byte;
    if (rel) begin
      grp.bytes = {sec_enc.b[2:0], rel_enc.b[2:0]};
      grp.count = COUNT_W'(3'd3 + sec_enc.len);
    end else begin
      grp.bytes = {16'h0000, sec_enc.b};
      grp.count = COUNT_W'(sec_enc.len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_PLAIN;
      digit_count <= '0;
      code_accum  <= '0;
      held_high   <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      code_accum  <= code_accum_next;
      held_high   <= held_high_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jsu_out_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_out_queue: result register and byte drain
// Holds one decoded group and shifts it out one byte per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_out_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  jsu_pkg::group_t grp,
  output logic            free,
  jsu_out_if.source       tx
);
  import jsu_pkg::*;

  logic [GROUP_BYTES-1:0][7:0] bytes;
  logic [COUNT_W-1:0]          count;
  logic                        last;
  logic                        take;

  assign tx.valid    = (count != '0);
  assign tx.out_byte = bytes[0];
  assign tx.out_last = last && (count == COUNT_W'(1));

  assign take = tx.valid && tx.ready;
  assign free = (count == '0) || (take && count == COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= grp.count;
    end else if (take) begin
      count <= count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= grp.bytes;
      last  <= grp.last;
    end else if (take) begin
      bytes <= {8'h00, bytes[GROUP_BYTES-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/json_string_unescape_utf8.sv =====
// An accepted input word waits in the input register; its group is loaded into
// the result register once the output queue is free, and the first output byte
// of the item is presented from that result register.
// Throughput: one input word per cycle while each item yields at most one byte
// and tx is ready; an n-byte item holds the single output port until drained.
// Reset (rst, synchronous) empties both registers and returns to plain text.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string unescaper
// Decodes backslash escapes and \uXXXX escapes, pairs UTF-16 surrogates and
// emits the result as UTF-8, one byte per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    rx,
  jsu_out_if.source tx
);
  import jsu_pkg::*;

  // Input register. It accepts a new word whenever it is empty or its word
  // moves into the decoder in the same cycle, so one more word can wait here
  // while the output queue is still draining the previous group.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // The decoder state advances only when the group it produces can be
  // stored: the queue is empty, or its final byte leaves this cycle.
  logic   fire;
  logic   free;
  logic   load;
  group_t grp;

  assign fire     = in_valid && free;
  assign load     = fire && (grp.count != '0);
  assign rx.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.data_byte;
      in_last <= rx.last_byte;
    end
  end

  // Escape and surrogate decoding between the input register and the
  // result group.
  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .last_byte (in_last),
    .grp       (grp)
  );

  // The result group is shifted out one byte per output word.
  jsu_out_queue u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .grp  (grp),
    .free (free),
    .tx   (tx)
  );

endmodule

`default_nettype wire
